// ----- src/mexp_pkg.sv -----
// shared types and constants for the modular exponentiation core
package mexp_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } mexp_state_t;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  // register byte address
  localparam logic [2:0] ADDR_MODULUS = 3'd0;

endpackage

// ----- src/mexp_mulmod.sv -----
// iterative shift-and-add modular multiplier, one multiplier bit per cycle
module mexp_mulmod import mexp_pkg::*; #(
  parameter int WORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] n,
  output logic [WORD_BITS-1:0] result,
  output mm_stat_t             stat
);

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] b_r;
  logic [WORD_BITS-1:0] acc;
  logic [CNT_BITS-1:0]  cnt;
  logic                 busy;
  logic                 done;

  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS-1:0] dred;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS-1:0] sred;

  // acc = 2*acc mod n, then add a mod n when the current multiplier bit is set
  always_comb begin
    dbl  = {1'b0, acc} + {1'b0, acc};
    dred = (dbl >= {1'b0, n}) ? WORD_BITS'(dbl - {1'b0, n}) : dbl[WORD_BITS-1:0];
    sum  = {1'b0, dred} + (b_r[WORD_BITS-1] ? {1'b0, a_r} : {(WORD_BITS+1){1'b0}});
    sred = (sum >= {1'b0, n}) ? WORD_BITS'(sum - {1'b0, n}) : sum[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
      cnt <= CNT_BITS'(WORD_BITS - 1);
    end else if (busy) begin
      acc <= sred;
      b_r <= {b_r[WORD_BITS-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign result    = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- src/modular_exponentiation_core.sv -----
// Modular exponentiation core: power_mod = base ** exponent mod modulus, left-to-right
// square-and-multiply on one shared shift-and-add modular multiplier. A transaction first
// reduces the base (one product pass), then squares once per exponent bit and multiplies
// once per set bit. Loading the result waits while an earlier result still holds the output
// register. A modulus below two gives 0. in_stall is high from acceptance until the result
// is loaded into the output register; the output register lets the next transaction start
// while a result still waits. modulus is written over the APB port at byte address 0 and
// must only change while the core is idle.
module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int WORD_BITS = 16,
  localparam int DATA_BITS = (WORD_BITS > 32) ? 64 : 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] power_mod
);

  localparam int CNT_BITS = $clog2(WORD_BITS);

  mexp_state_t          state;
  mexp_state_t          state_next;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] ereg;
  logic [WORD_BITS-1:0] breg;
  logic [WORD_BITS-1:0] acc;
  logic [CNT_BITS-1:0]  bit_idx;

  logic                 mod_small;
  logic                 out_free;
  logic                 ebit;
  logic                 last_bit;
  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_a;
  logic [WORD_BITS-1:0] mm_b;
  logic [WORD_BITS-1:0] mm_result;
  mm_stat_t             mm_stat;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_BITS'(2);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MODULUS) begin
      modulus <= pwdata[WORD_BITS-1:0];
    end
  end

  assign prdata = (paddr == ADDR_MODULUS) ? DATA_BITS'(modulus) : '0;

  assign mod_small = (modulus[WORD_BITS-1:1] == '0);
  assign out_free  = !out_valid || !out_stall;
  assign ebit      = ereg[bit_idx];
  assign last_bit  = (bit_idx == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = mod_small ? ST_FINISH : ST_REDUCE;
      end
      ST_REDUCE: begin
        if (mm_stat.done) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          if (ebit) state_next = ST_MULT;
          else if (last_bit) state_next = ST_FINISH;
        end
      end
      ST_MULT: begin
        if (mm_stat.done) state_next = last_bit ? ST_FINISH : ST_SQUARE;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: input stall, multiplier launch and operand select
  always_comb begin
    in_stall = 1'b1;
    mm_start = 1'b0;
    mm_a     = mm_result;
    mm_b     = mm_result;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        mm_start = in_valid && !mod_small;
        mm_a     = WORD_BITS'(1);
        mm_b     = base;
      end
      ST_REDUCE: begin
        // first square is of the initial accumulator value one
        mm_start = mm_stat.done;
        mm_a     = WORD_BITS'(1);
        mm_b     = WORD_BITS'(1);
      end
      ST_SQUARE: begin
        mm_start = mm_stat.done && (ebit || !last_bit);
        if (ebit) mm_b = breg;
      end
      ST_MULT: begin
        mm_start = mm_stat.done && !last_bit;
      end
      ST_FINISH: begin
        mm_start = 1'b0;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ereg    <= exponent;
          acc     <= '0;
          bit_idx <= CNT_BITS'(WORD_BITS - 1);
        end
      end
      ST_REDUCE: begin
        if (mm_stat.done) breg <= mm_result;
      end
      ST_SQUARE: begin
        if (mm_stat.done) begin
          acc <= mm_result;
          if (!ebit && !last_bit) bit_idx <= bit_idx - 1'b1;
        end
      end
      ST_MULT: begin
        if (mm_stat.done) begin
          acc <= mm_result;
          if (!last_bit) bit_idx <= bit_idx - 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) power_mod <= acc;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  mexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .n     (modulus),
    .result(mm_result),
    .stat  (mm_stat)
  );

  // never launch a product while one is in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier started while busy");

  // a finished product only arrives while the sequencer waits for one
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> (state == ST_REDUCE || state == ST_SQUARE || state == ST_MULT))
    else $error("product finished outside a wait state");

  // a new result only comes out of the finish state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) ##1 out_valid |-> $past(state) == ST_FINISH)
    else $error("result loaded outside finish state");

  // no multiplier activity while the sequencer is idle or in the finish state
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FINISH) |-> !mm_stat.busy)
    else $error("multiplier busy while sequencer idle");

endmodule

// ----- dv/testbench.sv -----
// testbench for modular_exponentiation_core with a power-mod scoreboard
module testbench import mexp_pkg::*; ();

  localparam int WORD_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int LATENCY = 600;
  localparam int CYCLE_LIMIT = 3000000;

  typedef logic [WORD_BITS-1:0] word_t;

  class power_scoreboard;
    word_t modulus = 2;
    word_t expected_powers[$];
    int errors = 0;

    // square-and-multiply over all exponent bits, msb first
    function word_t expected_power(word_t b, word_t e);
      logic [31:0] n;
      logic [31:0] r;
      logic [31:0] acc;
      if (modulus < 2) return '0;
      n = 32'(modulus);
      r = 32'(b) % n;
      acc = 1;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
        acc = (acc * acc) % n;
        if (e[i]) acc = (acc * r) % n;
      end
      return acc[WORD_BITS-1:0];
    endfunction

    function void note_input(word_t b, word_t e);
      expected_powers.push_back(expected_power(b, e));
    endfunction

    function void check_result(word_t got);
      word_t want;
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_powers.pop_front();
      if (got !== want) begin
        $display("%0t: power_mod mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  word_t                base = '0;
  word_t                exponent = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  word_t                power_mod;

  power_scoreboard sb;
  bit quiet = 1'b0;
  int cycles = 0;

  modular_exponentiation_core #(.WORD_BITS(WORD_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .base(base),
    .exponent(exponent),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power_mod(power_mod)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_item(input word_t b, input word_t e);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    base <= b;
    exponent <= e;
    do @(posedge clk); while (in_stall);
    sb.note_input(b, e);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // write then read back in back-to-back transfers; psel stays high between them
  task automatic set_modulus(input word_t value, input bit junk_upper);
    logic [DATA_BITS-1:0] data;
    logic [DATA_BITS-1:0] got;
    data = {junk_upper ? 16'($urandom) : 16'h0, value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MODULUS;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.modulus = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[WORD_BITS-1:0] !== value) begin
      $display("%0t: modulus readback mismatch, expected %0d, actual %0d",
               $time, value, got[WORD_BITS-1:0]);
      sb.errors++;
    end
  endtask

  task automatic run_random(input int count);
    word_t n;
    word_t b;
    word_t e;
    n = sb.modulus;
    repeat (count) begin
      case ($urandom_range(0, 5))
        3: b = (n > 1) ? word_t'($urandom_range(0, n - 1)) : word_t'($urandom);
        4: b = n - 1 + word_t'($urandom_range(0, 2));
        5: b = $urandom_range(0, 1) ? word_t'('1) : word_t'($urandom_range(0, 1));
        default: b = word_t'($urandom);
      endcase
      case ($urandom_range(0, 7))
        5: e = word_t'($urandom_range(0, 20));
        6: begin
          case ($urandom_range(0, 4))
            0: e = 0;
            1: e = 1;
            2: e = 3;
            3: e = 17;
            default: e = '1;
          endcase
        end
        7: e = word_t'(1) << $urandom_range(0, WORD_BITS - 1);
        default: e = word_t'($urandom);
      endcase
      send_item(b, e);
    end
  endtask

  // receiving side: random stall ahead of each result
  initial begin
    int hold;
    wait (!rst);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(power_mod);
    end
  end

  initial begin
    word_t moduli[10];
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset modulus of two
    send_item(16'd0, 16'd0);
    send_item(16'd1, 16'd1);
    send_item(16'hffff, 16'hffff);
    drain();

    set_modulus(16'hffff, 1'b1);
    send_item(16'd0, 16'd0);
    send_item(16'd0, 16'hffff);
    send_item(16'hffff, 16'd0);
    send_item(16'hffff, 16'hffff);
    send_item(16'hfffe, 16'hffff);
    send_item(16'd1, 16'hffff);
    send_item(16'd2, 16'd15);
    send_item(16'd2, 16'd16);
    send_item(16'd3, 16'h8000);
    send_item(16'd12345, 16'd1);
    drain();

    // textbook key: n = 61 * 53, e = 17, d = 2753
    set_modulus(16'd3233, 1'b0);
    send_item(16'd65, 16'd17);
    send_item(16'd2790, 16'd2753);
    drain();

    // moduli below two give zero for everything
    set_modulus(16'd0, 1'b1);
    send_item(16'd5, 16'd0);
    send_item(16'hffff, 16'hffff);
    drain();
    set_modulus(16'd1, 1'b0);
    send_item(16'd0, 16'd0);
    send_item(16'd7, 16'd3);
    drain();

    moduli = '{16'hffff, 16'd65521, 16'd3233, 16'd2, 16'd3, 16'h8000,
               word_t'($urandom_range(2, 65535)), word_t'($urandom_range(2, 255)),
               16'd0, 16'd1};
    foreach (moduli[i]) begin
      quiet = (i % 4 == 3);
      set_modulus(moduli[i], 1'($urandom_range(0, 1)));
      run_random(80);
      drain();
    end
    quiet = 1'b0;

    repeat (LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
